FILE: rtl/sclip3d_pkg.sv
// Shared types and codes for the 3D segment slab clipper.
package sclip3d_pkg;

  localparam int COORD_BITS  = 32;
  localparam int MAG_BITS    = COORD_BITS + 1;
  localparam int PROD_BITS   = 2 * MAG_BITS;
  localparam int MINLEN_BITS = 16;

  localparam logic [MINLEN_BITS-1:0] MIN_LENGTH_RESET = 16'd5;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [MAG_BITS-1:0]          mag_t;
  typedef logic [PROD_BITS-1:0]         prod_t;
  typedef logic [2:0][COORD_BITS-1:0]   point_t;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  typedef enum logic [1:0] {
    CLS_BELOW  = 2'd0,
    CLS_INSIDE = 2'd1,
    CLS_ABOVE  = 2'd2
  } cls_t;

  typedef enum logic [1:0] {
    ST_OUTSIDE = 2'd0,
    ST_INSIDE  = 2'd1,
    ST_CLIPPED = 2'd2,
    ST_SHORT   = 2'd3
  } st_t;

  typedef struct packed {
    logic [1:0] kind;
    coord_t     start_x;
    coord_t     start_y;
    coord_t     start_z;
    coord_t     end_x;
    coord_t     end_y;
    coord_t     end_z;
    coord_t     layer_low;
    coord_t     layer_high;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    coord_t     out_start_x;
    coord_t     out_start_y;
    coord_t     out_start_z;
    coord_t     out_end_x;
    coord_t     out_end_y;
    coord_t     out_end_z;
  } out_word_t;

  typedef struct packed {
    logic [1:0] kind;
    cls_t       cls0;
    cls_t       cls1;
    point_t     p0;
    point_t     p1;
    coord_t     face0;
    coord_t     face1;
  } side_t;

endpackage

FILE: rtl/sclip3d_cell.sv
// One restoring division step: consumes one dividend bit, emits one quotient bit.
module sclip3d_cell import sclip3d_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [MAG_BITS-1:0]   up_rem,
  input  logic [PROD_BITS-1:0]  up_num,
  input  logic [COORD_BITS-1:0] up_quo,
  input  logic [MAG_BITS-1:0]   up_dd,
  input  logic                  up_neg,
  input  logic [COORD_BITS-1:0] up_base,
  output logic [MAG_BITS-1:0]   rem,
  output logic [PROD_BITS-1:0]  num,
  output logic [COORD_BITS-1:0] quo,
  output logic [MAG_BITS-1:0]   dd,
  output logic                  neg,
  output logic [COORD_BITS-1:0] base
);

  logic [MAG_BITS:0] trial;
  logic [MAG_BITS:0] diff;
  logic              ge;

  assign trial = {up_rem, up_num[PROD_BITS-1]};
  assign diff  = trial - {1'b0, up_dd};
  assign ge    = trial >= {1'b0, up_dd};

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= ge ? diff[MAG_BITS-1:0] : trial[MAG_BITS-1:0];
      num  <= {up_num[PROD_BITS-2:0], 1'b0};
      // only the low quotient bits survive the wrap of the result
      quo  <= {up_quo[COORD_BITS-2:0], ge};
      dd   <= up_dd;
      neg  <= up_neg;
      base <= up_base;
    end
  end

endmodule

FILE: rtl/sclip3d_lane.sv
// One interpolation lane: split multiply, chain of divide cells, signed rounding.
module sclip3d_lane import sclip3d_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [MAG_BITS-1:0]   mul_a,
  input  logic [MAG_BITS-1:0]   mul_b,
  input  logic [MAG_BITS-1:0]   divisor,
  input  logic                  negate,
  input  logic [COORD_BITS-1:0] start,
  output coord_t                value
);

  localparam int LO_BITS = (MAG_BITS + 1) / 2;
  localparam int HI_BITS = MAG_BITS - LO_BITS;

  logic [2*LO_BITS-1:0]       pp_ll;
  logic [LO_BITS+HI_BITS-1:0] pp_lh;
  logic [LO_BITS+HI_BITS-1:0] pp_hl;
  logic [2*HI_BITS-1:0]       pp_hh;
  logic [MAG_BITS-1:0]        m1_dd;
  logic                       m1_neg;
  logic [COORD_BITS-1:0]      m1_base;

  logic [PROD_BITS-1:0]       m2_prod;
  logic [MAG_BITS-1:0]        m2_dd;
  logic                       m2_neg;
  logic [COORD_BITS-1:0]      m2_base;

  logic [MAG_BITS-1:0]   c_rem  [0:PROD_BITS];
  logic [PROD_BITS-1:0]  c_num  [0:PROD_BITS];
  logic [COORD_BITS-1:0] c_quo  [0:PROD_BITS];
  logic [MAG_BITS-1:0]   c_dd   [0:PROD_BITS];
  logic                  c_neg  [0:PROD_BITS];
  logic [COORD_BITS-1:0] c_base [0:PROD_BITS];

  logic [COORD_BITS-1:0] r1_q;
  logic [MAG_BITS-1:0]   r1_r;
  logic [MAG_BITS-1:0]   r1_dd;
  logic [COORD_BITS-1:0] r1_base;

  logic [MAG_BITS:0]     twice_r;
  logic                  round_up;
  logic [MAG_BITS-1:0]   last_rem;
  logic                  rem_nz;

  // partial products, halves of each magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll   <= {{LO_BITS{1'b0}}, mul_a[LO_BITS-1:0]} *
                 {{LO_BITS{1'b0}}, mul_b[LO_BITS-1:0]};
      pp_lh   <= {{HI_BITS{1'b0}}, mul_a[LO_BITS-1:0]} *
                 {{LO_BITS{1'b0}}, mul_b[MAG_BITS-1:LO_BITS]};
      pp_hl   <= {{LO_BITS{1'b0}}, mul_a[MAG_BITS-1:LO_BITS]} *
                 {{HI_BITS{1'b0}}, mul_b[LO_BITS-1:0]};
      pp_hh   <= {{HI_BITS{1'b0}}, mul_a[MAG_BITS-1:LO_BITS]} *
                 {{HI_BITS{1'b0}}, mul_b[MAG_BITS-1:LO_BITS]};
      m1_dd   <= divisor;
      m1_neg  <= negate;
      m1_base <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_prod <= {pp_hh, pp_ll} + (prod_t'(pp_lh) << LO_BITS) + (prod_t'(pp_hl) << LO_BITS);
      m2_dd   <= m1_dd;
      m2_neg  <= m1_neg;
      m2_base <= m1_base;
    end
  end

  assign c_rem[0]  = '0;
  assign c_num[0]  = m2_prod;
  assign c_quo[0]  = '0;
  assign c_dd[0]   = m2_dd;
  assign c_neg[0]  = m2_neg;
  assign c_base[0] = m2_base;

  for (genvar i = 0; i < PROD_BITS; i++) begin : g_cell
    sclip3d_cell u_cell (
      .clk     (clk),
      .en      (en),
      .up_rem  (c_rem[i]),
      .up_num  (c_num[i]),
      .up_quo  (c_quo[i]),
      .up_dd   (c_dd[i]),
      .up_neg  (c_neg[i]),
      .up_base (c_base[i]),
      .rem     (c_rem[i+1]),
      .num     (c_num[i+1]),
      .quo     (c_quo[i+1]),
      .dd      (c_dd[i+1]),
      .neg     (c_neg[i+1]),
      .base    (c_base[i+1])
    );
  end

  assign last_rem = c_rem[PROD_BITS];
  assign rem_nz   = last_rem != '0;

  // negative quotient: floor toward minus infinity, -(q+1) is ~q
  always_ff @(posedge clk) begin
    if (en) begin
      if (c_neg[PROD_BITS]) begin
        r1_q <= rem_nz ? ~c_quo[PROD_BITS] : -c_quo[PROD_BITS];
        r1_r <= rem_nz ? c_dd[PROD_BITS] - last_rem : last_rem;
      end else begin
        r1_q <= c_quo[PROD_BITS];
        r1_r <= last_rem;
      end
      r1_dd   <= c_dd[PROD_BITS];
      r1_base <= c_base[PROD_BITS];
    end
  end

  // round half to even on the wrapped sum
  assign twice_r  = {r1_r, 1'b0};
  assign round_up = (twice_r > {1'b0, r1_dd}) ||
                    ((twice_r == {1'b0, r1_dd}) && (r1_base[0] ^ r1_q[0]));

  always_ff @(posedge clk) begin
    if (en) begin
      value <= coord_t'(r1_base + r1_q + {{(COORD_BITS-1){1'b0}}, round_up});
    end
  end

endmodule

FILE: rtl/segment_slab_clipper_3d.sv
// Top level of the 3D segment slab clipper.
//
// Clips one integer segment per word to the slab layer_low..layer_high on the
// axis chosen by kind. Input words arrive on seg (seg_valid/seg_ready), results
// leave on clip (clip_valid/clip_ready), one result word per input word, in order.
// min_length is written through cfg_wen/cfg_wdata; the user must do so only while
// the block is idle, as the block itself does not enforce it.
// Throughput: one word per cycle while the skid register is empty. The depth
// is set by the divide chain, one cell per bit of the 66-bit product, behind
// three operand stages, a two-stage split multiplier, two rounding stages and
// two length-check stages. Four lanes run in parallel, one per interpolated
// coordinate of each endpoint.
//
// Reset (rst, synchronous) empties the pipeline and the output and sets
// min_length to 5. When clip_ready is low the result holds on clip and the
// next finished word moves into a one-word skid register; the whole pipeline
// stalls only once that skid register is full, and seg_ready drops with it.
module segment_slab_clipper_3d import sclip3d_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [MINLEN_BITS-1:0] cfg_wdata,
  input  logic                   seg_valid,
  output logic                   seg_ready,
  input  in_word_t               seg,
  output logic                   clip_valid,
  input  logic                   clip_ready,
  output out_word_t              clip
);

  localparam int LANE_LAT = PROD_BITS + 4;
  localparam int SIDE_LAT = LANE_LAT + 2;
  localparam int SQ_BITS  = 2 * MINLEN_BITS;
  localparam int SUM_BITS = SQ_BITS + 2;

  function automatic mag_t mag_of(logic [MAG_BITS-1:0] v);
    return v[MAG_BITS-1] ? mag_t'(-v) : mag_t'(v);
  endfunction

  function automatic cls_t classify(coord_t v, coord_t lo, coord_t hi);
    if (v < lo) return CLS_BELOW;
    if (v > hi) return CLS_ABOVE;
    return CLS_INSIDE;
  endfunction

  logic                   en;
  logic [MINLEN_BITS-1:0] min_length;

  // operand stages
  side_t                  side_q [0:SIDE_LAT];
  logic                   v_q    [0:SIDE_LAT];
  side_t                  a0_side;
  coord_t                 ax_s, ax_e;
  coord_t                 oth_s  [2];
  coord_t                 oth_e  [2];
  logic [MAG_BITS-1:0]    a1_span;
  logic [MAG_BITS-1:0]    a1_num [2];
  logic [MAG_BITS-1:0]    a1_do  [2];
  coord_t                 a1_so  [2];
  mag_t                   op_dd;
  mag_t                   op_a    [2][2];
  mag_t                   op_b    [2][2];
  logic                   op_neg  [2][2];
  coord_t                 op_base [2][2];
  coord_t                 lv      [2][2];

  // assembly and length check
  side_t                  fs;
  point_t                 r0, r1;
  logic [MAG_BITS-1:0]    dlt  [3];
  mag_t                   dmag [3];
  st_t                    pre_status;
  logic                   f1_valid;
  st_t                    f1_status;
  point_t                 f1_r0, f1_r1;
  logic [MINLEN_BITS-1:0] f1_d16 [3];
  logic                   f1_big;
  logic                   f2_valid;
  st_t                    f2_status;
  point_t                 f2_r0, f2_r1;
  logic [SQ_BITS-1:0]     f2_sq [3];
  logic [SQ_BITS-1:0]     f2_lim;
  logic                   f2_big;
  logic [SUM_BITS-1:0]    len_sq;
  st_t                    fin_status;
  out_word_t              out_next;
  logic                   incoming;

  // skid
  logic                   skid_valid;
  out_word_t              skid;

  assign en        = !skid_valid;
  // no word is taken while reset clears the pipe
  assign seg_ready = en && !rst;
  assign incoming  = en && f2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= MIN_LENGTH_RESET;
    end else if (cfg_wen) begin
      min_length <= cfg_wdata;
    end
  end

  // stage A0: classify endpoints, pick faces
  always_comb begin
    a0_side.kind  = seg.kind;
    a0_side.p0    = {seg.start_z, seg.start_y, seg.start_x};
    a0_side.p1    = {seg.end_z, seg.end_y, seg.end_x};
    case (seg.kind)
      AXIS_X: begin
        a0_side.cls0 = classify(seg.start_x, seg.layer_low, seg.layer_high);
        a0_side.cls1 = classify(seg.end_x, seg.layer_low, seg.layer_high);
      end
      AXIS_Y: begin
        a0_side.cls0 = classify(seg.start_y, seg.layer_low, seg.layer_high);
        a0_side.cls1 = classify(seg.end_y, seg.layer_low, seg.layer_high);
      end
      default: begin
        a0_side.cls0 = classify(seg.start_z, seg.layer_low, seg.layer_high);
        a0_side.cls1 = classify(seg.end_z, seg.layer_low, seg.layer_high);
      end
    endcase
    a0_side.face0 = (a0_side.cls0 == CLS_BELOW) ? seg.layer_low : seg.layer_high;
    a0_side.face1 = (a0_side.cls1 == CLS_BELOW) ? seg.layer_low : seg.layer_high;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= a0_side;
      for (int i = 1; i <= SIDE_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= SIDE_LAT; i++) begin
        v_q[i] <= 1'b0;
      end
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (en) begin
      v_q[0] <= seg_valid;
      for (int i = 1; i <= SIDE_LAT; i++) begin
        v_q[i] <= v_q[i-1];
      end
      f1_valid <= v_q[SIDE_LAT];
      f2_valid <= f1_valid;
    end
  end

  // stage A1: axis and other coordinates, signed spans
  always_comb begin
    case (side_q[0].kind)
      AXIS_X: begin
        ax_s = side_q[0].p0[0];    ax_e = side_q[0].p1[0];
        oth_s[0] = side_q[0].p0[1]; oth_e[0] = side_q[0].p1[1];
        oth_s[1] = side_q[0].p0[2]; oth_e[1] = side_q[0].p1[2];
      end
      AXIS_Y: begin
        ax_s = side_q[0].p0[1];    ax_e = side_q[0].p1[1];
        oth_s[0] = side_q[0].p0[0]; oth_e[0] = side_q[0].p1[0];
        oth_s[1] = side_q[0].p0[2]; oth_e[1] = side_q[0].p1[2];
      end
      default: begin
        ax_s = side_q[0].p0[2];    ax_e = side_q[0].p1[2];
        oth_s[0] = side_q[0].p0[0]; oth_e[0] = side_q[0].p1[0];
        oth_s[1] = side_q[0].p0[1]; oth_e[1] = side_q[0].p1[1];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_span   <= {ax_e[COORD_BITS-1], ax_e} - {ax_s[COORD_BITS-1], ax_s};
      a1_num[0] <= {side_q[0].face0[COORD_BITS-1], side_q[0].face0} -
                   {ax_s[COORD_BITS-1], ax_s};
      a1_num[1] <= {side_q[0].face1[COORD_BITS-1], side_q[0].face1} -
                   {ax_s[COORD_BITS-1], ax_s};
      for (int k = 0; k < 2; k++) begin
        a1_do[k] <= {oth_e[k][COORD_BITS-1], oth_e[k]} - {oth_s[k][COORD_BITS-1], oth_s[k]};
        a1_so[k] <= oth_s[k];
      end
    end
  end

  // stage A2: magnitudes and quotient sign per lane
  always_ff @(posedge clk) begin
    if (en) begin
      op_dd <= mag_of(a1_span);
      for (int e = 0; e < 2; e++) begin
        for (int k = 0; k < 2; k++) begin
          op_a[e][k]    <= mag_of(a1_num[e]);
          op_b[e][k]    <= mag_of(a1_do[k]);
          op_neg[e][k]  <= a1_num[e][MAG_BITS-1] ^ a1_do[k][MAG_BITS-1] ^
                           a1_span[MAG_BITS-1];
          op_base[e][k] <= a1_so[k];
        end
      end
    end
  end

  for (genvar e = 0; e < 2; e++) begin : g_end
    for (genvar k = 0; k < 2; k++) begin : g_coord
      sclip3d_lane u_lane (
        .clk     (clk),
        .en      (en),
        .mul_a   (op_a[e][k]),
        .mul_b   (op_b[e][k]),
        .divisor (op_dd),
        .negate  (op_neg[e][k]),
        .start   (op_base[e][k]),
        .value   (lv[e][k])
      );
    end
  end

  // stage F1: rebuild endpoints, deltas for the length check
  assign fs = side_q[SIDE_LAT];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (fs.cls0 == CLS_INSIDE) begin
        r0[j] = fs.p0[j];
      end else if (2'(j) == fs.kind) begin
        r0[j] = fs.face0;
      end else begin
        r0[j] = lv[0][(j == 2) || ((j == 1) && (fs.kind != AXIS_X))];
      end
      if (fs.cls1 == CLS_INSIDE) begin
        r1[j] = fs.p1[j];
      end else if (2'(j) == fs.kind) begin
        r1[j] = fs.face1;
      end else begin
        r1[j] = lv[1][(j == 2) || ((j == 1) && (fs.kind != AXIS_X))];
      end
      dlt[j]  = {r1[j][COORD_BITS-1], r1[j]} - {r0[j][COORD_BITS-1], r0[j]};
      dmag[j] = mag_of(dlt[j]);
    end
    if (fs.kind == AXIS_NONE) begin
      pre_status = ST_OUTSIDE;
    end else if (fs.cls0 == fs.cls1) begin
      pre_status = (fs.cls0 == CLS_INSIDE) ? ST_INSIDE : ST_OUTSIDE;
    end else begin
      pre_status = ST_CLIPPED;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_status <= pre_status;
      f1_r0     <= r0;
      f1_r1     <= r1;
      f1_big    <= (dmag[0][MAG_BITS-1:MINLEN_BITS] != '0) ||
                   (dmag[1][MAG_BITS-1:MINLEN_BITS] != '0) ||
                   (dmag[2][MAG_BITS-1:MINLEN_BITS] != '0);
      for (int j = 0; j < 3; j++) begin
        f1_d16[j] <= dmag[j][MINLEN_BITS-1:0];
      end
    end
  end

  // stage F2: squares
  always_ff @(posedge clk) begin
    if (en) begin
      f2_status <= f1_status;
      f2_r0     <= f1_r0;
      f2_r1     <= f1_r1;
      f2_big    <= f1_big;
      f2_lim    <= {{MINLEN_BITS{1'b0}}, min_length} * {{MINLEN_BITS{1'b0}}, min_length};
      for (int j = 0; j < 3; j++) begin
        f2_sq[j] <= {{MINLEN_BITS{1'b0}}, f1_d16[j]} * {{MINLEN_BITS{1'b0}}, f1_d16[j]};
      end
    end
  end

  // final: sum, compare, zero empty results
  always_comb begin
    len_sq = {2'b00, f2_sq[0]} + {2'b00, f2_sq[1]} + {2'b00, f2_sq[2]};
    fin_status = f2_status;
    if ((f2_status == ST_CLIPPED) && !f2_big && (len_sq < {2'b00, f2_lim})) begin
      fin_status = ST_SHORT;
    end
    out_next.status = fin_status;
    if ((fin_status == ST_OUTSIDE) || (fin_status == ST_SHORT)) begin
      out_next.out_start_x = '0;
      out_next.out_start_y = '0;
      out_next.out_start_z = '0;
      out_next.out_end_x   = '0;
      out_next.out_end_y   = '0;
      out_next.out_end_z   = '0;
    end else begin
      out_next.out_start_x = coord_t'(f2_r0[0]);
      out_next.out_start_y = coord_t'(f2_r0[1]);
      out_next.out_start_z = coord_t'(f2_r0[2]);
      out_next.out_end_x   = coord_t'(f2_r1[0]);
      out_next.out_end_y   = coord_t'(f2_r1[1]);
      out_next.out_end_z   = coord_t'(f2_r1[2]);
    end
  end

  // output register plus one-word skid
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (clip_valid && !clip_ready) begin
      if (incoming) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      clip_valid <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      clip_valid <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (clip_valid && !clip_ready) begin
      if (incoming) begin
        skid <= out_next;
      end
    end else if (skid_valid) begin
      clip <= skid;
    end else if (incoming) begin
      clip <= out_next;
    end
  end

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for segment_slab_clipper_3d.
`timescale 1ns / 1ps

module testbench;
  import sclip3d_pkg::*;

  localparam int IDLE_PCT    = 27;
  localparam int DRAIN_WAIT  = 100;   // comfortably above the pipeline latency
  localparam int STALL_LIMIT = 5000;  // cycles with no word moving on either side

  logic                   clk;
  logic                   rst;
  logic                   cfg_wen;
  logic [MINLEN_BITS-1:0] cfg_wdata;
  logic                   seg_valid;
  logic                   seg_ready;
  in_word_t               seg;
  logic                   clip_valid;
  logic                   clip_ready;
  out_word_t              clip;

  segment_slab_clipper_3d uut (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .seg_valid(seg_valid), .seg_ready(seg_ready), .seg(seg),
    .clip_valid(clip_valid), .clip_ready(clip_ready), .clip(clip)
  );

  // Directed stimulus row: a word plus, where obvious, its typed-in result.
  typedef struct {
    in_word_t  w;
    bit        fixed;
    out_word_t res;
  } seg_row_t;

  seg_row_t               seg_rows[$];
  out_word_t              pending_clips[$];  // results owed by the block, oldest first
  logic [MINLEN_BITS-1:0] min_len;           // mirror of the min_length register
  bit                     row_fixed;         // typed result for the word now on seg
  out_word_t              row_res;
  bit                     calm;              // no idling on either side while set
  int                     fails;
  int                     quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Exact interpolation s_o + (face - s_a) * d_o / d_a, nearest, ties to even,
  // wrapped to the coordinate width. Floor division keeps the remainder >= 0.
  function automatic logic [COORD_BITS-1:0] lerp_coord(longint s_a, longint face,
                                                       longint d_a, longint s_o,
                                                       longint d_o);
    logic signed [127:0] num, den, quo, rem;
    logic [63:0]         base;
    if (d_a == 0) return s_o[COORD_BITS-1:0];
    num = face - s_a;
    num = num * d_o;
    den = d_a;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    quo = num / den;
    rem = num % den;
    if (rem < 0) begin
      quo = quo - 1;
      rem = rem + den;
    end
    base = s_o + quo[63:0];
    if (2 * rem > den || (2 * rem == den && base[0])) base = base + 1;
    return base[COORD_BITS-1:0];
  endfunction

  function automatic int slab_class(longint v, longint lo, longint hi);
    if (v < lo) return CLS_BELOW;
    if (v > hi) return CLS_ABOVE;
    return CLS_INSIDE;
  endfunction

  // Expected clip result of one segment word under the given min_length.
  function automatic out_word_t clip_segment(in_word_t w, logic [MINLEN_BITS-1:0] ml);
    out_word_t              o;
    longint                 pt[2][3];
    longint                 lo, hi, face, gap, len_sq;
    int                     ax, cls[2];
    logic [COORD_BITS-1:0]  cut[2][3];
    bit                     far;
    o = '0;
    if (w.kind == AXIS_NONE) return o;
    ax = w.kind;
    pt[0][0] = w.start_x; pt[0][1] = w.start_y; pt[0][2] = w.start_z;
    pt[1][0] = w.end_x;   pt[1][1] = w.end_y;   pt[1][2] = w.end_z;
    lo = w.layer_low;
    hi = w.layer_high;
    cls[0] = slab_class(pt[0][ax], lo, hi);
    cls[1] = slab_class(pt[1][ax], lo, hi);
    if (cls[0] == cls[1]) begin
      if (cls[0] == CLS_INSIDE) begin
        o = {ST_INSIDE, w.start_x, w.start_y, w.start_z, w.end_x, w.end_y, w.end_z};
      end
      return o;
    end
    for (int e = 0; e < 2; e++) begin
      face = (cls[e] == CLS_BELOW) ? lo : hi;
      for (int j = 0; j < 3; j++) begin
        if (cls[e] == CLS_INSIDE) cut[e][j] = pt[e][j][COORD_BITS-1:0];
        else if (j == ax)         cut[e][j] = face[COORD_BITS-1:0];
        else cut[e][j] = lerp_coord(pt[0][ax], face, pt[1][ax] - pt[0][ax],
                                    pt[0][j], pt[1][j] - pt[0][j]);
      end
    end
    // Length test on the wrapped coordinates; any axis span over 16 bits is long enough.
    len_sq = 0;
    far = 1'b0;
    for (int j = 0; j < 3; j++) begin
      gap = longint'(coord_t'(cut[1][j])) - longint'(coord_t'(cut[0][j]));
      if (gap < 0) gap = -gap;
      if (gap > 65535) far = 1'b1;
      else len_sq += gap * gap;
    end
    if (!far && len_sq < longint'(ml) * longint'(ml)) begin
      o.status = ST_SHORT;
      return o;
    end
    o = {ST_CLIPPED, cut[0][0], cut[0][1], cut[0][2], cut[1][0], cut[1][1], cut[1][2]};
    return o;
  endfunction

  function automatic in_word_t make_seg(axis_t k, coord_t sx, coord_t sy, coord_t sz,
                                        coord_t ex, coord_t ey, coord_t ez,
                                        coord_t lo, coord_t hi);
    in_word_t w;
    w = {k, sx, sy, sz, ex, ey, ez, lo, hi};
    return w;
  endfunction

  task automatic add_row(in_word_t w, bit fixed, out_word_t res);
    seg_row_t r;
    r.w = w;
    r.fixed = fixed;
    r.res = res;
    seg_rows.push_back(r);
  endtask

  // Mostly small coordinates near the slab so segments cross it; some full range.
  function automatic coord_t pick_coord(bit wide);
    if (wide) return coord_t'($urandom);
    return coord_t'($urandom_range(2000)) - 1000;
  endfunction

  function automatic in_word_t random_seg();
    in_word_t w;
    bit       wide;
    coord_t   a, b;
    wide = ($urandom_range(9) < 2);
    w.kind = ($urandom_range(19) == 0) ? AXIS_NONE : axis_t'($urandom_range(2));
    w.start_x = pick_coord(wide); w.start_y = pick_coord(wide);
    w.start_z = pick_coord(wide); w.end_x = pick_coord(wide);
    w.end_y = pick_coord(wide);   w.end_z = pick_coord(wide);
    a = wide ? coord_t'($urandom) : coord_t'($urandom_range(600)) - 300;
    b = wide ? coord_t'($urandom) : coord_t'($urandom_range(600)) - 300;
    // Usually ordered bounds; now and then reversed on purpose.
    if ((a > b) != ($urandom_range(9) == 0)) begin
      w.layer_low = b;
      w.layer_high = a;
    end else begin
      w.layer_low = a;
      w.layer_high = b;
    end
    return w;
  endfunction

  // Offer one word on seg, with random gaps before it, until it is taken.
  task automatic send_seg(in_word_t w, bit fixed, out_word_t res);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      seg_valid = 1'b0;
      @(negedge clk);
    end
    seg = w;
    row_fixed = fixed;
    row_res = res;
    seg_valid = 1'b1;
    do @(posedge clk); while (!seg_ready);
  endtask

  // Register write only once the pipe has drained.
  task automatic write_min_length(logic [MINLEN_BITS-1:0] v);
    @(negedge clk);
    seg_valid = 1'b0;
    wait (pending_clips.size() == 0);
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_wdata = v;
    cfg_wen = 1'b1;
    min_len = v;
    @(negedge clk);
    cfg_wen = 1'b0;
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) send_seg(random_seg(), 1'b0, '0);
  endtask

  // Receiver: random back-pressure on clip, none while calm.
  always @(negedge clk) begin
    clip_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Accepted segment word: queue its expected result.
  always @(posedge clk) begin
    if (!rst && seg_valid && seg_ready) begin
      pending_clips.push_back(row_fixed ? row_res : clip_segment(seg, min_len));
    end
  end

  // Accepted result word: compare with the oldest expectation.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && clip_valid && clip_ready) begin
      if (pending_clips.size() == 0) begin
        $error("clip word with nothing expected: %h", clip);
        fails++;
      end else begin
        want = pending_clips.pop_front();
        if (clip.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, clip.status); fails++;
        end
        if (clip.out_start_x != want.out_start_x) begin
          $error("out_start_x: expected %0d, got %0d", want.out_start_x, clip.out_start_x);
          fails++;
        end
        if (clip.out_start_y != want.out_start_y) begin
          $error("out_start_y: expected %0d, got %0d", want.out_start_y, clip.out_start_y);
          fails++;
        end
        if (clip.out_start_z != want.out_start_z) begin
          $error("out_start_z: expected %0d, got %0d", want.out_start_z, clip.out_start_z);
          fails++;
        end
        if (clip.out_end_x != want.out_end_x) begin
          $error("out_end_x: expected %0d, got %0d", want.out_end_x, clip.out_end_x);
          fails++;
        end
        if (clip.out_end_y != want.out_end_y) begin
          $error("out_end_y: expected %0d, got %0d", want.out_end_y, clip.out_end_y);
          fails++;
        end
        if (clip.out_end_z != want.out_end_z) begin
          $error("out_end_z: expected %0d, got %0d", want.out_end_z, clip.out_end_z);
          fails++;
        end
      end
    end
  end

  // Watchdog: nothing moving on either side for too long ends the run.
  always @(posedge clk) begin
    if (rst || (seg_valid && seg_ready) || (clip_valid && clip_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    coord_t    cmin, cmax;
    out_word_t empty;
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    seg_valid = 1'b0;
    seg = '0;
    row_fixed = 1'b0;
    row_res = '0;
    calm = 1'b0;
    min_len = MIN_LENGTH_RESET;
    cmin = {1'b1, {(COORD_BITS-1){1'b0}}};
    cmax = {1'b0, {(COORD_BITS-1){1'b1}}};
    empty = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, min_length at its reset value.
    // Unused axis selector: always empty, whatever the coordinates.
    add_row(make_seg(AXIS_NONE, 1, 2, 3, 4, 5, 6, 0, 10), 1'b1, empty);
    // Whole segment inside the slab comes back unchanged.
    add_row(make_seg(AXIS_X, 1, 2, 3, 4, 5, 6, 0, 10), 1'b1,
            {ST_INSIDE, 32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd5, 32'sd6});
    // Both endpoints below, then both above: empty.
    add_row(make_seg(AXIS_Y, 0, -5, 0, 9, -1, 9, 0, 10), 1'b1, empty);
    add_row(make_seg(AXIS_Z, 0, 0, 11, 9, 9, 99, 0, 10), 1'b1, empty);
    add_row(make_seg(AXIS_X, cmax, cmin, cmax, cmax, cmax, cmin, cmin, 0), 1'b1, empty);
    // Extreme bounds hold every point: whole, extremes unchanged.
    add_row(make_seg(AXIS_Y, cmin, cmin, cmin, cmax, cmax, cmax, cmin, cmax), 1'b1,
            {ST_INSIDE, cmin, cmin, cmin, cmax, cmax, cmax});
    // Crossings on each axis, with one or both endpoints outside.
    add_row(make_seg(AXIS_X, -10, 0, 0, 10, 20, 40, 0, 50), 1'b0, empty);
    add_row(make_seg(AXIS_Y, 3, 100, -7, -33, 0, 91, 20, 60), 1'b0, empty);
    add_row(make_seg(AXIS_Z, 5, -5, 200, 17, 44, -200, -50, 50), 1'b0, empty);
    // Both ends outside on opposite faces.
    add_row(make_seg(AXIS_X, -100, 7, 3, 100, -9, 77, -20, 30), 1'b0, empty);
    // Rounding tie plus a clip shorter than min_length.
    add_row(make_seg(AXIS_X, 0, 0, 0, 4, 1, 0, 2, 10), 1'b0, empty);
    add_row(make_seg(AXIS_X, 0, 0, 0, 4, 3, 0, 2, 10), 1'b0, empty);
    // Reversed bounds, low above high.
    add_row(make_seg(AXIS_X, -5, 1, 2, 20, 9, 8, 10, 0), 1'b0, empty);
    add_row(make_seg(AXIS_Z, cmax, cmin, cmin, cmin, cmax, cmax, cmax, cmin), 1'b0, empty);
    // Full-range crossing exercises the widest products.
    add_row(make_seg(AXIS_X, cmin, cmin, cmax, cmax, cmax, cmin, -1, 1), 1'b0, empty);
    add_row(make_seg(AXIS_Y, cmax, cmax, cmin, cmin, cmin, cmax, 0, cmax), 1'b0, empty);
    foreach (seg_rows[i]) send_seg(seg_rows[i].w, seg_rows[i].fixed, seg_rows[i].res);

    // Random part over several min_length settings, extremes included.
    write_min_length(16'd0);
    send_random(200);
    write_min_length(16'hffff);
    send_random(100);
    write_min_length(16'd3);
    send_random(100);
    calm = 1'b1;        // long stretch with no idling on either side
    send_random(200);
    calm = 1'b0;
    write_min_length(MINLEN_BITS'($urandom));
    send_random(300);

    @(negedge clk);
    seg_valid = 1'b0;
    wait (pending_clips.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fails == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
